@@ hw/rtl/bth_pkg.sv @@
`timescale 1ns / 1ps
// Package for the boundary-tag heap allocator: sizes, codes, sequencer states
// and small helpers for tag fields and store addressing. No dependencies.
package bth_pkg;

  // Heap store geometry.
  localparam int HEAP_WORDS = 4096;
  localparam int HEAP_BYTES = HEAP_WORDS * 4;
  localparam int MEM_AW     = $clog2(HEAP_WORDS);
  localparam int WORD_W     = 32;
  // Break counts bytes and may equal HEAP_BYTES.
  localparam int BRK_W      = $clog2(HEAP_BYTES) + 1;
  // Internal byte pointers; wide enough for sums of tag sizes.
  localparam int PTR_W      = 36;

  // Field widths of the item.
  localparam int BYTES_W  = 14;
  localparam int CHUNK_W  = 15;
  localparam int ASIZE_W  = 15;
  localparam int GSIZE_W  = 16;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // Who asked for heap growth.
  typedef enum logic {
    CALL_BUILD,
    CALL_ALLOC
  } caller_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE, S_START, S_BUILD,
    S_A0, S_SR1, S_SR1W, S_SR2, S_SR2W, S_AGROW, S_ACHK,
    S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL5,
    S_F0, S_F1, S_F2, S_F3, S_F4,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_MRV, S_MRW, S_MRET,
    S_G0, S_G1, S_G2, S_G3, S_GRET,
    S_DONE
  } state_t;

  // Block size held in a tag: the low three bits are flags.
  function automatic logic [WORD_W-1:0] tag_size(input logic [WORD_W-1:0] w);
    return {w[WORD_W-1:3], 3'b000};
  endfunction

  // Store word index of a byte pointer; wraps modulo the store depth.
  function automatic logic [MEM_AW-1:0] word_of(input logic [PTR_W-1:0] b);
    return b[MEM_AW+1:2];
  endfunction

endpackage

@@ hw/rtl/bth_ram.sv @@
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module bth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/boundary_tag_heap_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the boundary-tag heap allocator: request sequencer and result
// register around one heap store RAM. Uses bth_pkg and bth_ram.
//
// The block takes one allocate or free item at a time and returns one result
// item for each. All heap tags live in a 4096 x 32 RAM with one read and one
// write port and registered read data; the sequencer performs each tag read
// and write in turn, so the cost of an item is set by the number of RAM
// accesses it needs. A null free, a zero-size allocate and a rejected free
// end soonest. A free costs more when it merges with the next block and more
// still when it merges with the previous one. An allocate costs more for
// every block header the next-fit search visits and for each search pass
// that runs out at the break or at the old rover. Growing the heap adds its
// own accesses; when it cannot grow, the item ends with an exhausted status
// after the search. The first request that touches the heap also builds it.
// A finished result waits in the output register while the next item is
// accepted. The user must write the chunk size register through the cfg port
// only while no item is in flight; the block itself does not enforce this.
module boundary_tag_heap_allocator
  import bth_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CHUNK_W-1:0] chunk_bytes,
  // Request channel.
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               kind,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic [BYTES_W-1:0] block_address,
  // Result channel.
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [BYTES_W-1:0] result_address,
  output logic [1:0]         status
);

  // Control state.
  state_t             st, st_next;
  logic               heap_ready, heap_ready_next;
  logic [BRK_W-1:0]   brk, brk_next;
  logic [PTR_W-1:0]   rover, rover_next;
  logic [CHUNK_W-1:0] chunk;
  logic               rsp_valid_next;
  logic [BYTES_W-1:0] result_address_next;
  logic [1:0]         status_next;

  // Working registers of the current item.
  logic               req_kind, req_kind_next;
  logic [BYTES_W-1:0] req_size, req_size_next;
  logic [BYTES_W-1:0] free_addr, free_addr_next;
  logic [PTR_W-1:0]   bp, bp_next;
  logic [PTR_W-1:0]   pb, pb_next;
  logic [PTR_W-1:0]   r, r_next;
  logic [PTR_W-1:0]   old_rover, old_rover_next;
  logic [PTR_W-1:0]   nxt, nxt_next;
  logic [PTR_W-1:0]   msize, msize_next;
  logic [ASIZE_W-1:0] asize, asize_next;
  logic [WORD_W-1:0]  hw, hw_next;
  logic [WORD_W-1:0]  nw, nw_next;
  logic [WORD_W-1:0]  pw, pw_next;
  logic [WORD_W-1:0]  tmp, tmp_next;
  logic [GSIZE_W-1:0] gsize, gsize_next;
  logic [CHUNK_W-3:0] grow_words, grow_words_next;
  caller_t            caller, caller_next;
  logic               from_free, from_free_next;
  logic [1:0]         bcnt, bcnt_next;
  logic [BYTES_W-1:0] fin_result, fin_result_next;
  logic [1:0]         fin_status, fin_status_next;

  // RAM port signals.
  logic               mem_we, mem_re;
  logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;

  // Helper values.
  logic [PTR_W-1:0]   rd_size;
  logic [CHUNK_W-1:0] req_plus3;
  logic [CHUNK_W-1:0] ext;
  logic [CHUNK_W-2:0] words_up;
  logic [WORD_W:0]    split_need;

  bth_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HEAP_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign cfg_ready = 1'b1;
  assign req_stall = (st != S_IDLE);

  assign rd_size    = PTR_W'(tag_size(mem_rdata));
  assign req_plus3  = CHUNK_W'(req_size) + CHUNK_W'(3);
  assign ext        = (CHUNK_W'(asize) > chunk) ? CHUNK_W'(asize) : chunk;
  assign words_up   = CHUNK_W'(grow_words) + CHUNK_W'(1) > 0 ?
                      (CHUNK_W-1)'(grow_words) + (CHUNK_W-1)'(1) : '0;
  assign split_need = (WORD_W+1)'(asize) + (WORD_W+1)'(8);

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      heap_ready <= 1'b0;
      brk        <= '0;
      rover      <= PTR_W'(8);
      chunk      <= CHUNK_W'(4096);
      rsp_valid  <= 1'b0;
    end else begin
      st         <= st_next;
      heap_ready <= heap_ready_next;
      brk        <= brk_next;
      rover      <= rover_next;
      rsp_valid  <= rsp_valid_next;
      if (cfg_valid && cfg_ready) begin
        chunk <= chunk_bytes;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    result_address <= result_address_next;
    status         <= status_next;
    req_kind       <= req_kind_next;
    req_size       <= req_size_next;
    free_addr      <= free_addr_next;
    bp             <= bp_next;
    pb             <= pb_next;
    r              <= r_next;
    old_rover      <= old_rover_next;
    nxt            <= nxt_next;
    msize          <= msize_next;
    asize          <= asize_next;
    hw             <= hw_next;
    nw             <= nw_next;
    pw             <= pw_next;
    tmp            <= tmp_next;
    gsize          <= gsize_next;
    grow_words     <= grow_words_next;
    caller         <= caller_next;
    from_free      <= from_free_next;
    bcnt           <= bcnt_next;
    fin_result     <= fin_result_next;
    fin_status     <= fin_status_next;
  end

  // Sequencer: next state, working values and RAM accesses.
  always_comb begin
    st_next             = st;
    heap_ready_next     = heap_ready;
    brk_next            = brk;
    rover_next          = rover;
    rsp_valid_next      = rsp_valid && rsp_stall;
    result_address_next = result_address;
    status_next         = status;
    req_kind_next       = req_kind;
    req_size_next       = req_size;
    free_addr_next      = free_addr;
    bp_next             = bp;
    pb_next             = pb;
    r_next              = r;
    old_rover_next      = old_rover;
    nxt_next            = nxt;
    msize_next          = msize;
    asize_next          = asize;
    hw_next             = hw;
    nw_next             = nw;
    pw_next             = pw;
    tmp_next            = tmp;
    gsize_next          = gsize;
    grow_words_next     = grow_words;
    caller_next         = caller;
    from_free_next      = from_free;
    bcnt_next           = bcnt;
    fin_result_next     = fin_result;
    fin_status_next     = fin_status;
    mem_we              = 1'b0;
    mem_waddr           = '0;
    mem_wdata           = '0;
    mem_re              = 1'b0;
    mem_raddr           = '0;

    case (st)
      // Wait for an item.
      S_IDLE: begin
        if (req_valid) begin
          req_kind_next  = kind;
          req_size_next  = request_bytes;
          free_addr_next = block_address;
          st_next        = S_START;
        end
      end

      // Dispatch on kind; ignore a null free and build the heap first where needed.
      S_START: begin
        bcnt_next = '0;
        if (req_kind == KIND_FREE && free_addr == '0) begin
          fin_result_next = '0;
          fin_status_next = ST_IGNORED;
          st_next         = S_DONE;
        end else if (!heap_ready) begin
          st_next = S_BUILD;
        end else if (req_kind == KIND_ALLOC) begin
          st_next = S_A0;
        end else begin
          st_next = S_F0;
        end
      end

      // Padding word, prologue header and footer, epilogue header.
      S_BUILD: begin
        mem_we    = 1'b1;
        mem_waddr = MEM_AW'(bcnt);
        case (bcnt)
          2'd0:    mem_wdata = '0;
          2'd3:    mem_wdata = WORD_W'(3);
          default: mem_wdata = WORD_W'(11);
        endcase
        bcnt_next = bcnt + 2'd1;
        if (bcnt == 2'd3) begin
          brk_next        = BRK_W'(16);
          rover_next      = PTR_W'(8);
          heap_ready_next = 1'b1;
          grow_words_next = chunk[CHUNK_W-1:2];
          caller_next     = CALL_BUILD;
          st_next         = S_G0;
        end
      end

      // Allocate: round the request and start the next-fit search.
      S_A0: begin
        if (req_size == '0) begin
          fin_result_next = '0;
          fin_status_next = ST_IGNORED;
          st_next         = S_DONE;
        end else begin
          asize_next     = ASIZE_W'((16'(req_plus3[CHUNK_W-1:3]) + 16'd1) << 3);
          old_rover_next = rover;
          r_next         = rover;
          st_next        = S_SR1;
        end
      end

      // Search from the rover up to the break.
      S_SR1: begin
        if (r < PTR_W'(brk)) begin
          mem_re    = 1'b1;
          mem_raddr = word_of(r - PTR_W'(4));
          st_next   = S_SR1W;
        end else begin
          r_next  = PTR_W'(8);
          st_next = S_SR2;
        end
      end

      S_SR1W: begin
        if (rd_size == '0) begin
          r_next  = PTR_W'(8);
          st_next = S_SR2;
        end else if (!mem_rdata[0] && PTR_W'(asize) <= rd_size) begin
          rover_next = r;
          bp_next    = r;
          st_next    = S_PL0;
        end else begin
          r_next  = r + rd_size;
          st_next = S_SR1;
        end
      end

      // Search from the first block up to the old rover.
      S_SR2: begin
        if (r < old_rover) begin
          mem_re    = 1'b1;
          mem_raddr = word_of(r - PTR_W'(4));
          st_next   = S_SR2W;
        end else begin
          rover_next = r;
          st_next    = S_AGROW;
        end
      end

      S_SR2W: begin
        if (rd_size == '0) begin
          rover_next = r;
          st_next    = S_AGROW;
        end else if (!mem_rdata[0] && PTR_W'(asize) <= rd_size) begin
          rover_next = r;
          bp_next    = r;
          st_next    = S_PL0;
        end else begin
          r_next  = r + rd_size;
          st_next = S_SR2;
        end
      end

      // No fit: grow by the larger of request and chunk size.
      S_AGROW: begin
        grow_words_next = ext[CHUNK_W-1:2];
        caller_next     = CALL_ALLOC;
        st_next         = S_G0;
      end

      S_ACHK: begin
        if (bp == '0) begin
          fin_result_next = '0;
          fin_status_next = ST_EXHAUSTED;
          st_next         = S_DONE;
        end else begin
          st_next = S_PL0;
        end
      end

      // Place: mark the block allocated, split off the rest if large enough.
      S_PL0: begin
        mem_re    = 1'b1;
        mem_raddr = word_of(bp - PTR_W'(4));
        st_next   = S_PL1;
      end

      S_PL1: begin
        tmp_next  = mem_rdata;
        mem_we    = 1'b1;
        mem_waddr = word_of(bp - PTR_W'(4));
        if ((WORD_W+1)'(tag_size(mem_rdata)) >= split_need) begin
          mem_wdata = WORD_W'(asize) | (mem_rdata & WORD_W'(2)) | WORD_W'(1);
          st_next   = S_PL2;
        end else begin
          mem_wdata = tag_size(mem_rdata) | (mem_rdata & WORD_W'(2)) | WORD_W'(1);
          st_next   = S_PL4;
        end
      end

      // Header of the split remainder.
      S_PL2: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(bp + PTR_W'(asize) - PTR_W'(4));
        mem_wdata = (tag_size(tmp) - WORD_W'(asize)) | WORD_W'(2);
        st_next   = S_PL3;
      end

      // Footer of the split remainder.
      S_PL3: begin
        mem_we          = 1'b1;
        mem_waddr       = word_of(bp + PTR_W'(tag_size(tmp)) - PTR_W'(8));
        mem_wdata       = tag_size(tmp) - WORD_W'(asize);
        fin_result_next = bp[BYTES_W-1:0];
        fin_status_next = ST_DONE;
        st_next         = S_DONE;
      end

      // Whole block used: set the next block's previous-allocated bit.
      S_PL4: begin
        mem_re    = 1'b1;
        mem_raddr = word_of(bp + PTR_W'(tag_size(tmp)) - PTR_W'(4));
        st_next   = S_PL5;
      end

      S_PL5: begin
        mem_we          = 1'b1;
        mem_waddr       = word_of(bp + PTR_W'(tag_size(tmp)) - PTR_W'(4));
        mem_wdata       = mem_rdata | WORD_W'(2);
        fin_result_next = bp[BYTES_W-1:0];
        fin_status_next = ST_DONE;
        st_next         = S_DONE;
      end

      // Free: read and check the header.
      S_F0: begin
        mem_re    = 1'b1;
        mem_raddr = word_of(PTR_W'(free_addr - BYTES_W'(4)));
        st_next   = S_F1;
      end

      S_F1: begin
        tmp_next = tag_size(mem_rdata);
        if (free_addr[2:0] != 3'd0 || free_addr < BYTES_W'(16) ||
            BRK_W'(free_addr) >= brk || !mem_rdata[0] ||
            rd_size < PTR_W'(8) ||
            PTR_W'(free_addr) + rd_size > PTR_W'(brk)) begin
          fin_result_next = '0;
          fin_status_next = ST_IGNORED;
          st_next         = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = word_of(PTR_W'(free_addr - BYTES_W'(4)));
          mem_wdata = tag_size(mem_rdata) | (mem_rdata & WORD_W'(2));
          st_next   = S_F2;
        end
      end

      // Footer of the freed block.
      S_F2: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(PTR_W'(free_addr) + PTR_W'(tmp) - PTR_W'(8));
        mem_wdata = tmp;
        st_next   = S_F3;
      end

      // Clear the next block's previous-allocated bit.
      S_F3: begin
        mem_re    = 1'b1;
        mem_raddr = word_of(PTR_W'(free_addr) + PTR_W'(tmp) - PTR_W'(4));
        st_next   = S_F4;
      end

      S_F4: begin
        mem_we         = 1'b1;
        mem_waddr      = word_of(PTR_W'(free_addr) + PTR_W'(tmp) - PTR_W'(4));
        mem_wdata      = mem_rdata & ~WORD_W'(2);
        bp_next        = PTR_W'(free_addr);
        from_free_next = 1'b1;
        st_next        = S_M0;
      end

      // Coalesce: read own header, then the next block's header.
      S_M0: begin
        mem_re    = 1'b1;
        mem_raddr = word_of(bp - PTR_W'(4));
        st_next   = S_M1;
      end

      S_M1: begin
        hw_next   = mem_rdata;
        nxt_next  = bp + rd_size;
        mem_re    = 1'b1;
        mem_raddr = word_of(bp + rd_size - PTR_W'(4));
        st_next   = S_M2;
      end

      S_M2: begin
        nw_next = mem_rdata;
        if (hw[1] && mem_rdata[0]) begin
          st_next = S_MRET;
        end else if (hw[1]) begin
          msize_next = PTR_W'(tag_size(hw)) + rd_size;
          mem_we     = 1'b1;
          mem_waddr  = word_of(bp - PTR_W'(4));
          mem_wdata  = (tag_size(hw) + tag_size(mem_rdata)) | WORD_W'(2);
          st_next    = S_M3;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = word_of(bp - PTR_W'(8));
          st_next   = S_M4;
        end
      end

      // Footer of the block merged with its successor.
      S_M3: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(bp + msize - PTR_W'(8));
        mem_wdata = msize[WORD_W-1:0];
        st_next   = S_MRV;
      end

      // Previous block is free: locate it from its footer.
      S_M4: begin
        pb_next   = bp - rd_size;
        mem_re    = 1'b1;
        mem_raddr = word_of(bp - rd_size - PTR_W'(4));
        st_next   = S_M5;
      end

      S_M5: begin
        pw_next = mem_rdata;
        mem_we  = 1'b1;
        if (nw[0]) begin
          msize_next = PTR_W'(tag_size(hw)) + rd_size;
          mem_waddr  = word_of(bp + PTR_W'(tag_size(hw)) - PTR_W'(8));
          mem_wdata  = tag_size(hw) + tag_size(mem_rdata);
        end else begin
          msize_next = PTR_W'(tag_size(hw)) + rd_size + PTR_W'(tag_size(nw));
          mem_waddr  = word_of(nxt + PTR_W'(tag_size(nw)) - PTR_W'(8));
          mem_wdata  = tag_size(hw) + tag_size(mem_rdata) + tag_size(nw);
        end
        st_next = S_M6;
      end

      // Header of the merged block at the previous block.
      S_M6: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(pb - PTR_W'(4));
        mem_wdata = msize[WORD_W-1:0] | (pw & WORD_W'(2));
        bp_next   = pb;
        st_next   = S_MRV;
      end

      // Pull the rover back if it points inside the merged block.
      S_MRV: begin
        mem_re    = 1'b1;
        mem_raddr = word_of(bp - PTR_W'(4));
        st_next   = S_MRW;
      end

      S_MRW: begin
        if (!bp[PTR_W-1] && rover > bp && rover < bp + rd_size) begin
          rover_next = bp;
        end
        st_next = S_MRET;
      end

      S_MRET: begin
        if (from_free) begin
          fin_result_next = '0;
          fin_status_next = ST_DONE;
          st_next         = S_DONE;
        end else begin
          st_next = S_GRET;
        end
      end

      // Grow: size the extension and check it against the store.
      S_G0: begin
        gsize_next     = {words_up[CHUNK_W-2:1], 3'b000};
        bp_next        = PTR_W'(brk);
        from_free_next = 1'b0;
        if (words_up[CHUNK_W-2:1] == '0 ||
            (BRK_W+2)'(brk) + (BRK_W+2)'({words_up[CHUNK_W-2:1], 3'b000}) >
            (BRK_W+2)'(HEAP_BYTES)) begin
          bp_next = '0;
          st_next = S_GRET;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = word_of(PTR_W'(brk) - PTR_W'(4));
          st_next   = S_G1;
        end
      end

      // New free block header over the old epilogue.
      S_G1: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(PTR_W'(brk) - PTR_W'(4));
        mem_wdata = WORD_W'(gsize) | (mem_rdata & WORD_W'(2));
        st_next   = S_G2;
      end

      // New free block footer.
      S_G2: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(PTR_W'(brk) + PTR_W'(gsize) - PTR_W'(8));
        mem_wdata = WORD_W'(gsize);
        st_next   = S_G3;
      end

      // New epilogue header, then coalesce with the old last block.
      S_G3: begin
        mem_we    = 1'b1;
        mem_waddr = word_of(PTR_W'(brk) + PTR_W'(gsize) - PTR_W'(4));
        mem_wdata = WORD_W'(1);
        brk_next  = BRK_W'(PTR_W'(brk) + PTR_W'(gsize));
        st_next   = S_M0;
      end

      S_GRET: begin
        if (caller == CALL_BUILD) begin
          st_next = S_START;
        end else begin
          st_next = S_ACHK;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next      = 1'b1;
          result_address_next = fin_result;
          status_next         = fin_status;
          st_next             = S_IDLE;
        end
      end

      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

endmodule
